>>> rtl/p80_pkg.sv
package p80_pkg;

  localparam int unsigned BlockW   = 64;
  localparam int unsigned KeyW     = 80;
  localparam int unsigned KeyLowW  = 64;
  localparam int unsigned KeyHighW = 16;
  localparam int unsigned NumRounds = 31;
  localparam int unsigned RndW     = 5;
  localparam int unsigned CfgIdxW  = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] KeyLowIdx  = 1'b0;
  localparam logic [CfgIdxW-1:0] KeyHighIdx = 1'b1;

  typedef struct packed {
    logic [BlockW-1:0] state;
    logic [KeyW-1:0]   key;
  } p80_item_t;

  function automatic logic [3:0] sbox4(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      default: y = 4'h2;
    endcase
    return y;
  endfunction

  function automatic logic [BlockW-1:0] sub_layer(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] r;
    for (int n = 0; n < BlockW / 4; n++) begin
      r[4*n +: 4] = sbox4(s[4*n +: 4]);
    end
    return r;
  endfunction

  // bit i moves to i/4 + 16*(i mod 4)
  function automatic logic [BlockW-1:0] perm_layer(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] r;
    for (int i = 0; i < BlockW; i++) begin
      r[(i / 4) + (BlockW / 4) * (i % 4)] = s[i];
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] round_key(input logic [KeyW-1:0] k);
    return k[KeyW-1 -: BlockW];
  endfunction

  // rotate right by 19, S-box on the top nibble, round number into bits 19..15
  function automatic logic [KeyW-1:0] key_next(input logic [KeyW-1:0] k,
                                               input logic [RndW-1:0] rnd);
    logic [KeyW-1:0] r;
    r = {k[18:0], k[KeyW-1:19]};
    r[KeyW-1 -: 4] = sbox4(r[KeyW-1 -: 4]);
    r[19:15] = r[19:15] ^ rnd;
    return r;
  endfunction

endpackage

>>> rtl/present80_block_encrypt.sv
// Channel   | Dir | Handshake                    | Payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata[63:0] plaintext
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata[63:0] ciphertext
// cfg       | in  | cfg_we_i                     | idx 0 key_low, idx 1 key_high
//
// One block per cycle while the skid is empty; a block passes the round stages, then the output register.
// Each of the 31 rounds is one register stage carrying state and key; the output
// register adds the final key.
// Reset clears all valid bits and both key registers.
// A skid register behind the output absorbs one result; s_axis_tready drops only
// while it is full, and the whole round pipeline holds then.
module present80_block_encrypt
  import p80_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [BlockW-1:0]    s_axis_tdata,   // [63:0] plaintext
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [BlockW-1:0]    m_axis_tdata,   // [63:0] ciphertext
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [KeyLowW-1:0]   cfg_wdata_i
);

  logic [KeyLowW-1:0]  key_low_q;
  logic [KeyHighW-1:0] key_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        KeyLowIdx:  key_low_q  <= cfg_wdata_i;
        KeyHighIdx: key_high_q <= cfg_wdata_i[KeyHighW-1:0];
        default: ;
      endcase
    end
  end

  logic                 pipe_en;
  logic                 s_fire;
  logic [NumRounds:0]   stg_valid;
  p80_item_t            stg_item [NumRounds+1];

  assign s_fire       = s_axis_tvalid && s_axis_tready;
  assign stg_valid[0] = s_axis_tvalid;
  assign stg_item[0]  = '{state: s_axis_tdata, key: {key_high_q, key_low_q}};

  for (genvar k = 0; k < NumRounds; k++) begin : g_round
    p80_round_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .rnd_i   (RndW'(k + 1)),
      .valid_i (stg_valid[k]),
      .item_i  (stg_item[k]),
      .valid_o (stg_valid[k+1]),
      .item_o  (stg_item[k+1])
    );
  end

  // output register plus skid
  logic              out_v_q, skid_v_q;
  logic [BlockW-1:0] out_q, skid_q;
  logic [BlockW-1:0] ct;
  logic              up_fire, out_fire;

  assign ct       = stg_item[NumRounds].state ^ round_key(stg_item[NumRounds].key);
  assign pipe_en  = !skid_v_q;
  assign up_fire  = pipe_en && stg_valid[NumRounds];
  assign out_fire = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_fire) begin
        skid_v_q <= 1'b0;
      end
    end else if (up_fire) begin
      if (out_v_q && !out_fire) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (up_fire) begin
      if (out_v_q && !out_fire) begin
        skid_q <= ct;
      end else begin
        out_q <= ct;
      end
    end
  end

  assign s_axis_tready = pipe_en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a result while output register is empty");

  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready && !skid_v_q && stg_valid[NumRounds]) |=> skid_v_q)
    else $error("result leaving the last round was not caught by the skid");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && m_axis_tready) |=> (out_v_q && !skid_v_q))
    else $error("skid did not drain into the output register");

  a_enter_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> stg_valid[1])
    else $error("accepted block did not enter the first round stage");

endmodule

>>> rtl/p80_round_stage.sv
module p80_round_stage
  import p80_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [RndW-1:0]     rnd_i,
  input  logic                valid_i,
  input  p80_item_t           item_i,
  output logic                valid_o,
  output p80_item_t           item_o
);

  logic      valid_q;
  p80_item_t item_q, item_d;

  always_comb begin
    item_d.state = perm_layer(sub_layer(item_i.state ^ round_key(item_i.key)));
    item_d.key   = key_next(item_i.key, rnd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
